// File: src/tpc_pkg.sv
// Package for the thresholded pixel centroid: payload types, widths, register codes.
`timescale 1ns / 1ps

package tpc_pkg;

    localparam int PIXEL_W  = 8;
    localparam int CENTER_W = 12;
    localparam int THRESH_W = 8;
    localparam int FWIDTH_W = 13;
    localparam int CFG_W    = 13;
    localparam int INDEX_W  = 1;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_THRESHOLD   = 1'b0;
    localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH = 1'b1;

    // Register reset values
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET   = 8'd128;
    localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RESET = 13'd640;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               end_of_frame;
    } pixel_in_t;

    typedef struct packed {
        logic                found;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
    } centroid_out_t;

endpackage

// File: src/thresholded_pixel_centroid_top.sv
// Top level of the thresholded pixel centroid with its shared restoring divider.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   pixel, end_of_frame
// out       output     out_valid / out_stall found, center_x, center_y
// cfg       input      cfg_write             cfg_index, cfg_data
//
// Ordinary pixels stream at one per cycle while in_stall is low.
// The end-of-frame pixel is followed by two divisions on one shared
// subtract-and-compare unit, each giving a QW-bit quotient (QW = bits of the
// larger of the column and row positions, 12 at the defaults), and then a
// load of the output register; in_stall stays high until that load is done.
// A frame with no bright pixel skips the divisions and goes straight to the load.
// The load waits while the previous result is still stalled in the
// output register. Reset at once clears control state, sums, counters and
// the configuration registers, not the divider or payload; a stalled result
// holds in the output register while the next frame's pixels are taken.
module thresholded_pixel_centroid_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  tpc_pkg::pixel_in_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output tpc_pkg::centroid_out_t       out_data,
    input  logic                         cfg_write,
    input  logic [tpc_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [tpc_pkg::CFG_W-1:0]    cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int QW = (CW > RW) ? CW : RW;
    localparam logic [63:0] LIMIT = 64'(MAX_WIDTH) * 64'(MAX_HEIGHT);
    localparam int NW = $clog2(LIMIT + 64'd1);
    localparam int SUM_W = QW + NW;
    localparam int SW = $clog2(QW + 1);
    localparam int DW = 17;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIVX = 2'd1;
    localparam logic [1:0] ST_DIVY = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [tpc_pkg::THRESH_W-1:0]    threshold_reg;
    logic [tpc_pkg::FWIDTH_W-1:0]    frame_width_reg;
    logic [CW-1:0]                   col_reg, col_next;
    logic [RW-1:0]                   row_reg, row_next;
    logic [SUM_W-1:0]                sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]                sum_y_reg, sum_y_next;
    logic [NW-1:0]                   count_reg, count_next;
    logic [NW-1:0]                   rem_reg, rem_next;
    logic [QW-1:0]                   quo_reg, quo_next;
    logic [QW-1:0]                   qx_reg, qx_next;
    logic [SW-1:0]                   step_reg, step_next;
    logic                            out_valid_reg, out_valid_next;
    tpc_pkg::centroid_out_t          out_data_reg, out_data_next;

    logic                            in_take;
    logic                            bright;
    logic [DW-1:0]                   eff_width;
    logic [DW-1:0]                   fw_ext;
    logic                            col_wrap;
    logic [NW:0]                     trial;
    logic [NW:0]                     diff;
    logic                            qbit;
    logic [QW+tpc_pkg::CENTER_W-1:0] cx_ext;
    logic [QW+tpc_pkg::CENTER_W-1:0] cy_ext;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Clamp the frame width to 1..MAX_WIDTH
    assign fw_ext = DW'(frame_width_reg);
    always_comb
    begin
        priority if (fw_ext == '0)
            eff_width = DW'(1);
        else if (fw_ext > DW'(MAX_WIDTH))
            eff_width = DW'(MAX_WIDTH);
        else
            eff_width = fw_ext;
    end

    assign col_wrap = (DW'(col_reg) + DW'(1)) >= eff_width;
    assign bright   = (in_data.pixel > threshold_reg) && (count_reg < NW'(LIMIT));

    // Shared divider step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign diff  = trial - {1'b0, count_reg};
    assign qbit  = (trial >= {1'b0, count_reg});

    assign cx_ext = (QW + tpc_pkg::CENTER_W)'(qx_reg);
    assign cy_ext = (QW + tpc_pkg::CENTER_W)'(quo_reg);

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        qx_next        = qx_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (bright)
                    begin
                        sum_x_next = sum_x_reg + SUM_W'(col_reg);
                        sum_y_next = sum_y_reg + SUM_W'(row_reg);
                        count_next = count_reg + NW'(1);
                    end
                    if (in_data.end_of_frame)
                    begin
                        col_next = '0;
                        row_next = '0;
                        if (bright || count_reg != '0)
                            state_next = ST_DIVX;
                        else
                            state_next = ST_LOAD;
                    end
                    else if (col_wrap)
                    begin
                        col_next = '0;
                        if ((DW'(row_reg) + DW'(1)) < DW'(MAX_HEIGHT))
                            row_next = row_reg + RW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
                // Preload the divider with the x sum
                rem_next  = sum_x_next[SUM_W-1:QW];
                quo_next  = sum_x_next[QW-1:0];
                step_next = '0;
            end
            ST_DIVX:
            begin
                rem_next  = qbit ? diff[NW-1:0] : trial[NW-1:0];
                quo_next  = QW'({quo_reg, qbit});
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(QW - 1))
                begin
                    qx_next    = QW'({quo_reg, qbit});
                    rem_next   = sum_y_reg[SUM_W-1:QW];
                    quo_next   = sum_y_reg[QW-1:0];
                    step_next  = '0;
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                rem_next  = qbit ? diff[NW-1:0] : trial[NW-1:0];
                quo_next  = QW'({quo_reg, qbit});
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(QW - 1))
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Hold until the output register is free, then load and clear
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg != '0)
                    begin
                        out_data_next.found    = 1'b1;
                        out_data_next.center_x = cx_ext[tpc_pkg::CENTER_W-1:0];
                        out_data_next.center_y = cy_ext[tpc_pkg::CENTER_W-1:0];
                    end
                    else
                    begin
                        out_data_next.found    = 1'b0;
                        out_data_next.center_x = '0;
                        out_data_next.center_y = '0;
                    end
                    sum_x_next = '0;
                    sum_y_next = '0;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= tpc_pkg::THRESHOLD_RESET;
            frame_width_reg <= tpc_pkg::FRAME_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tpc_pkg::REG_THRESHOLD:
                    threshold_reg <= cfg_data[tpc_pkg::THRESH_W-1:0];
                tpc_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[tpc_pkg::FWIDTH_W-1:0];
                default:
                    threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Divider and result payload
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        qx_reg       <= qx_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: test/thresholded_pixel_centroid_top_tb.sv
// Self-checking testbench for the thresholded pixel centroid top level.
`timescale 1ns / 1ps

module thresholded_pixel_centroid_top_tb;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int RANDOM_PIXELS = 560;
    localparam int WIDE_PIXELS   = 24;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam logic [24:0] BRIGHT_LIMIT = 25'(MAX_WIDTH * MAX_HEIGHT);

    // Predict centroids from accepted pixels and check them against the block
    class centroid_predictor;
        logic [tpc_pkg::THRESH_W-1:0] threshold;
        logic [tpc_pkg::FWIDTH_W-1:0] frame_width;
        logic [11:0]                  column_pos;
        logic [11:0]                  row_pos;
        logic [35:0]                  column_sum;
        logic [35:0]                  row_sum;
        logic [24:0]                  bright_count;
        tpc_pkg::centroid_out_t       expected_centroids[$];
        int unsigned                  mismatches;
        int unsigned                  centroids_checked;

        function void clear_frame();
            column_pos   = '0;
            row_pos      = '0;
            column_sum   = '0;
            row_sum      = '0;
            bright_count = '0;
        endfunction

        function void reset_state();
            threshold   = tpc_pkg::THRESHOLD_RESET;
            frame_width = tpc_pkg::FRAME_WIDTH_RESET;
            clear_frame();
            expected_centroids.delete();
            mismatches        = 0;
            centroids_checked = 0;
        endfunction

        function void write_reg(logic [tpc_pkg::INDEX_W-1:0] index,
                                logic [tpc_pkg::CFG_W-1:0] data);
            if (index == tpc_pkg::REG_THRESHOLD)
                threshold = data[tpc_pkg::THRESH_W-1:0];
            else if (index == tpc_pkg::REG_FRAME_WIDTH)
                frame_width = data[tpc_pkg::FWIDTH_W-1:0];
        endfunction

        function void take_pixel(tpc_pkg::pixel_in_t item);
            logic [13:0]            eff_width;
            logic [12:0]            column_next;
            tpc_pkg::centroid_out_t res;
            // Accumulate bright pixels until the count saturates
            if (item.pixel > threshold && bright_count < BRIGHT_LIMIT)
            begin
                column_sum   = column_sum + 36'(column_pos);
                row_sum      = row_sum + 36'(row_pos);
                bright_count = bright_count + 25'd1;
            end
            if (item.end_of_frame)
            begin
                res = '0;
                if (bright_count != 0)
                begin
                    res.found    = 1'b1;
                    res.center_x = 12'(column_sum / 36'(bright_count));
                    res.center_y = 12'(row_sum / 36'(bright_count));
                end
                expected_centroids.push_back(res);
                clear_frame();
                return;
            end
            // Advance the raster position; zero width acts as one, wide widths clip
            if (frame_width == 0)
                eff_width = 14'd1;
            else if (frame_width > MAX_WIDTH)
                eff_width = 14'(MAX_WIDTH);
            else
                eff_width = 14'(frame_width);
            column_next = 13'(column_pos) + 13'd1;
            if (14'(column_next) >= eff_width)
            begin
                column_pos = '0;
                if (row_pos < MAX_HEIGHT - 1)
                    row_pos = row_pos + 12'd1;
            end
            else
            begin
                column_pos = column_next[11:0];
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_centroid(tpc_pkg::centroid_out_t got);
            tpc_pkg::centroid_out_t exp_c;
            if (expected_centroids.size() == 0)
            begin
                report_mismatch($sformatf("centroid %p arrived with none pending", got));
                return;
            end
            exp_c = expected_centroids.pop_front();
            centroids_checked++;
            if (got.found !== exp_c.found)
                report_mismatch($sformatf("found %b, want %b", got.found, exp_c.found));
            if (got.center_x !== exp_c.center_x)
                report_mismatch($sformatf("center_x %0d, want %0d",
                                          got.center_x, exp_c.center_x));
            if (got.center_y !== exp_c.center_y)
                report_mismatch($sformatf("center_y %0d, want %0d",
                                          got.center_y, exp_c.center_y));
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    tpc_pkg::pixel_in_t            in_data;
    logic                          out_valid;
    logic                          out_stall;
    tpc_pkg::centroid_out_t        out_data;
    logic                          cfg_write;
    logic [tpc_pkg::INDEX_W-1:0]   cfg_index;
    logic [tpc_pkg::CFG_W-1:0]     cfg_data;

    centroid_predictor    predictor;
    bit                   offering;
    bit                   sender_gaps;
    bit                   receiver_gaps;
    bit                   long_hold_req;
    int unsigned          cycle_count = 0;
    int unsigned          pixels_sent;
    int unsigned          frames_sent;
    int unsigned          settings_used;

    thresholded_pixel_centroid_top #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Check results; outputs and stall are stable at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            predictor.check_centroid(out_data);
    end

    // Drive the result-side stall: random bursts and one long hold-off
    initial
    begin : receiver
        int unsigned burst;
        bit          hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (receiver_gaps && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst - 1) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Drop valid if an item is being offered
    task automatic stop_offer();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offer one pixel and hold it until accepted
    task automatic send_pixel(input logic [tpc_pkg::PIXEL_W-1:0] pix, input logic eof);
        tpc_pkg::pixel_in_t item;
        item.pixel        = pix;
        item.end_of_frame = eof;
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            stop_offer();
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        offering = 1'b1;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        predictor.take_pixel(item);
        pixels_sent++;
        if (eof)
            frames_sent++;
        @(posedge clk);
    endtask

    // Wait until every pending centroid is out and the divider is quiet
    task automatic wait_drain();
        stop_offer();
        @(posedge clk);
        while (predictor.expected_centroids.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on an idle block
    task automatic set_config(input logic [tpc_pkg::CFG_W-1:0] thr_word,
                              input logic [tpc_pkg::CFG_W-1:0] width_word);
        cfg_write <= 1'b1;
        cfg_index <= tpc_pkg::REG_THRESHOLD;
        cfg_data  <= thr_word;
        @(posedge clk);
        predictor.write_reg(tpc_pkg::REG_THRESHOLD, thr_word);
        cfg_index <= tpc_pkg::REG_FRAME_WIDTH;
        cfg_data  <= width_word;
        @(posedge clk);
        predictor.write_reg(tpc_pkg::REG_FRAME_WIDTH, width_word);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Pick a pixel that often lands on the threshold boundary
    function automatic logic [tpc_pkg::PIXEL_W-1:0] pick_pixel(
        logic [tpc_pkg::THRESH_W-1:0] thr);
        case ($urandom_range(0, 6))
            0: return thr;
            1: return thr + 8'd1;
            2: return 8'hFF;
            3: return 8'h00;
            default: return tpc_pkg::PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one frame of random content
    task automatic random_frame(input int unsigned len);
        bit dark;
        logic [tpc_pkg::PIXEL_W-1:0] pix;
        dark = ($urandom_range(0, 7) == 0);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (dark)
                pix = tpc_pkg::PIXEL_W'($urandom_range(0, predictor.threshold));
            else
                pix = pick_pixel(predictor.threshold);
            send_pixel(pix, i == len - 1);
        end
    endtask

    // Choose a random register setting, extremes included
    task automatic random_config();
        logic [tpc_pkg::CFG_W-1:0] thr_word;
        logic [tpc_pkg::CFG_W-1:0] width_word;
        thr_word = tpc_pkg::CFG_W'($urandom_range(0, 8191));
        case ($urandom_range(0, 4))
            0: thr_word[tpc_pkg::THRESH_W-1:0] = 8'h00;
            1: thr_word[tpc_pkg::THRESH_W-1:0] = 8'hFF;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: width_word = 13'd0;
            1: width_word = 13'd1;
            2: width_word = 13'(MAX_WIDTH);
            3: width_word = 13'h1FFF;
            4: width_word = tpc_pkg::CFG_W'($urandom_range(MAX_WIDTH + 1, 8191));
            default: width_word = tpc_pkg::CFG_W'($urandom_range(2, 16));
        endcase
        set_config(thr_word, width_word);
    endtask

    initial
    begin : main
        int unsigned random_start;
        int unsigned frames_left;
        int unsigned len;
        bit pressure_done;

        predictor = new();
        predictor.reset_state();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_write     = 1'b0;
        cfg_index     = tpc_pkg::REG_THRESHOLD;
        cfg_data      = '0;
        offering      = 1'b0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        long_hold_req = 1'b0;
        pixels_sent   = 0;
        frames_sent   = 0;
        settings_used = 0;
        pressure_done = 1'b0;

        // Hold reset, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, threshold edge, lone and dark frames
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd129, 1'b0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd0, 1'b1);
        wait_drain();

        // Directed: zero width acts as one pixel per row, threshold zero
        set_config(13'd0, 13'd0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd255, 1'b1);
        wait_drain();

        // Directed: top threshold never counts, width beyond the maximum
        set_config(13'h1FFF, 13'h1FFF);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
        wait_drain();

        // Directed: two rows of three
        set_config(13'd10, 13'd3);
        send_pixel(8'd11, 1'b0);
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd90, 1'b0);
        send_pixel(8'd3, 1'b0);
        send_pixel(8'd77, 1'b0);
        send_pixel(8'd12, 1'b1);
        wait_drain();

        // Widest row: short frame, bright pixel at its last pixel only
        set_config(13'd100, 13'(MAX_WIDTH));
        for (int unsigned i = 0; i < WIDE_PIXELS; i++)
            send_pixel((i == WIDE_PIXELS - 1) ? 8'd255 : 8'd0, i == WIDE_PIXELS - 1);
        wait_drain();

        // Random phases of frames under changing settings
        random_start = pixels_sent;
        frames_left  = 0;
        while (pixels_sent - random_start < RANDOM_PIXELS)
        begin
            if (frames_left == 0)
            begin
                wait_drain();
                random_config();
                frames_left = $urandom_range(3, 10);
                // Hold the receiver off while frames keep coming, then drain
                if (!pressure_done && pixels_sent - random_start > RANDOM_PIXELS / 3)
                begin
                    pressure_done = 1'b1;
                    sender_gaps   = 1'b0;
                    long_hold_req = 1'b1;
                    for (int unsigned f = 0; f < 12; f++)
                        random_frame($urandom_range(1, 6));
                    wait_drain();
                    sender_gaps = 1'b1;
                end
            end
            // Quiet both sides for the last stretch
            if (pixels_sent - random_start > RANDOM_PIXELS - 120)
            begin
                sender_gaps   = 1'b0;
                receiver_gaps = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(25, 120);
            else
                len = $urandom_range(1, 24);
            random_frame(len);
            frames_left--;
        end

        // Let every centroid come out
        wait_drain();
        if (predictor.expected_centroids.size() != 0)
            predictor.report_mismatch("centroids still pending at the end");

        $display("covered %0d pixels in %0d frames under %0d register settings",
                 pixels_sent, frames_sent, settings_used);
        $display("%0d centroids checked, %0d mismatches",
                 predictor.centroids_checked, predictor.mismatches);
        if (predictor.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
